>>> rtl/fixed_block_pool_allocator_top_macros.svh
// Assertion macros used by the block pool allocator RTL.
`ifndef FIXED_BLOCK_POOL_ALLOCATOR_TOP_MACROS_SVH
`define FIXED_BLOCK_POOL_ALLOCATOR_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define FBPA_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define FBPA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/fbpa_pkg.sv
// Types, constants and codes of the fixed block pool allocator.
package fbpa_pkg;

  localparam int MAX_BLOCKS      = 1024;
  localparam int WORD_BYTES      = 8;     // power of two
  localparam int MAX_BLOCK_BYTES = 4096;

  localparam int IDX_W      = $clog2(MAX_BLOCKS);
  localparam int LINK_W     = $clog2(MAX_BLOCKS + 1);
  localparam int WORD_SHIFT = $clog2(WORD_BYTES);
  localparam int STRIDE_W   = $clog2(MAX_BLOCK_BYTES / WORD_BYTES + 1);

  localparam int ACTION_W   = 3;
  localparam int STATUS_W   = 3;
  localparam int OFF_W      = 22;
  localparam int CNT_W      = 11;
  localparam int CTR_W      = 32;
  localparam int BYTES_W    = 13;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 13;

  localparam int DIVD_W     = OFF_W - WORD_SHIFT;
  localparam int STEP_W     = $clog2(DIVD_W + 1);

  localparam logic [LINK_W-1:0] LINK_NULL = LINK_W'(MAX_BLOCKS);

  localparam int RESET_BLOCK_BYTES  = 8;
  localparam int RESET_POOL_BLOCKS  = 1024;
  localparam int RESET_STRIDE_WORDS = (RESET_BLOCK_BYTES + WORD_BYTES - 1) / WORD_BYTES;

  typedef enum logic [ACTION_W-1:0] {
    ACT_ALLOC       = 3'd0,
    ACT_FREE        = 3'd1,
    ACT_RESET_STATS = 3'd2,
    ACT_INIT        = 3'd3,
    ACT_CLEANUP     = 3'd4
  } action_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK          = 3'd0,
    ST_EXHAUSTED   = 3'd1,
    ST_NOT_READY   = 3'd2,
    ST_FREE_REJECT = 3'd3,
    ST_BAD_COUNT   = 3'd4
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BLOCK_BYTES = 1'b0,
    CFG_POOL_BLOCKS = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [OFF_W-1:0]    free_offset;
  } cmd_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [OFF_W-1:0]    block_offset;
    logic [CNT_W-1:0]    used_count;
    logic [CNT_W-1:0]    peak_count;
    logic [CTR_W-1:0]    alloc_total;
    logic [CTR_W-1:0]    free_total;
    logic [CTR_W-1:0]    fail_total;
    logic                list_empty;
    logic                all_free;
  } result_t;

  typedef struct packed {
    logic                go;
    logic [DIVD_W-1:0]   dividend;
    logic [STRIDE_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                done;
    logic [DIVD_W-1:0]   quot;
    logic [STRIDE_W-1:0] rem;
  } div_rsp_t;

endpackage

>>> rtl/fbpa_link_ram.sv
// Link memory: one write port, one read port, registered read data.
module fbpa_link_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 11
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/fbpa_div.sv
// Restoring divider, one quotient bit per cycle, for offset-to-block mapping.
module fbpa_div (
  input  logic                clk,
  input  logic                rst,
  input  fbpa_pkg::div_req_t  req,
  output fbpa_pkg::div_rsp_t  rsp
);

  logic                                running;
  logic                                done;
  logic [fbpa_pkg::STEP_W-1:0]         steps;
  logic [fbpa_pkg::STRIDE_W-1:0]       rem;
  logic [fbpa_pkg::STRIDE_W-1:0]       dvsr;
  logic [fbpa_pkg::DIVD_W-1:0]         quot;
  logic [fbpa_pkg::STRIDE_W:0]         trial;
  logic [fbpa_pkg::STRIDE_W:0]         diff;
  logic                                fits;

  // shift in the next dividend bit and try the subtraction
  always_comb begin
    trial = {rem, quot[fbpa_pkg::DIVD_W-1]};
    diff  = trial - {1'b0, dvsr};
    fits  = (trial >= {1'b0, dvsr});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.go) begin
        running <= 1'b1;
      end else if (running && steps == fbpa_pkg::STEP_W'(1)) begin
        running <= 1'b0;
        done    <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.go) begin
      steps <= fbpa_pkg::STEP_W'(fbpa_pkg::DIVD_W);
      rem   <= '0;
      quot  <= req.dividend;
      dvsr  <= req.divisor;
    end else if (running) begin
      steps <= steps - fbpa_pkg::STEP_W'(1);
      rem   <= fits ? diff[fbpa_pkg::STRIDE_W-1:0] : trial[fbpa_pkg::STRIDE_W-1:0];
      quot  <= {quot[fbpa_pkg::DIVD_W-2:0], fits};
    end
  end

  assign rsp.done = done;
  assign rsp.quot = quot;
  assign rsp.rem  = rem;

endmodule

>>> rtl/fixed_block_pool_allocator_top.sv
// Top level of the fixed block pool allocator: command decode, free list head, statistics.
// Alloc from a ready, non-empty pool: link read, then head update and result.
// Free on a ready pool: result once the bit-serial offset divider (19 steps) is done.
// Init with a nonzero count: min(pool_blocks, 1024) links, one link written per cycle.
// Everything else answers from idle with no wait state; busy holds start off until done.
// Done strobes each result once, no stall. Reset empties the pool and clears stats, not links.
`include "fixed_block_pool_allocator_top_macros.svh"

module fixed_block_pool_allocator_top (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  fbpa_pkg::cmd_t                   cmd,
  output logic                             done,
  output fbpa_pkg::result_t                result,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [fbpa_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [fbpa_pkg::CFG_DATA_W-1:0]  cfg_data
);

  // Sequencer states, one-hot.
  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_ALLOC = 4'b0010,   // link read in flight
    S_FREE  = 4'b0100,   // waiting on the divider
    S_INIT  = 4'b1000    // writing the initial chain
  } state_t;

  state_t state;

  // Configuration registers, sampled at init.
  logic [fbpa_pkg::BYTES_W-1:0]  cfg_block_bytes;
  logic [fbpa_pkg::CNT_W-1:0]    cfg_pool_blocks;

  // Pool state.
  logic [fbpa_pkg::LINK_W-1:0]   head;
  logic                          pool_ready;
  logic [fbpa_pkg::LINK_W-1:0]   linked;
  logic [fbpa_pkg::STRIDE_W-1:0] stride_words;   // block stride in words
  // Used and peak keep full width: a repeated free can grow the list past the pool.
  logic [fbpa_pkg::CTR_W-1:0]    used;
  logic [fbpa_pkg::CTR_W-1:0]    peak;
  logic [fbpa_pkg::CTR_W-1:0]    alloc_ctr;
  logic [fbpa_pkg::CTR_W-1:0]    free_ctr;
  logic [fbpa_pkg::CTR_W-1:0]    fail_ctr;

  // Init walk.
  logic [fbpa_pkg::IDX_W-1:0]    init_idx;
  logic [fbpa_pkg::IDX_W-1:0]    init_last;

  // Result payload.
  fbpa_pkg::status_e             status_q;
  logic [fbpa_pkg::DIVD_W-1:0]   off_words;
  logic [fbpa_pkg::WORD_SHIFT-1:0] free_lsb;

  // Datapath.
  logic                          accept;
  logic                          list_empty;
  logic [fbpa_pkg::LINK_W-1:0]   cnt_sat;
  logic [fbpa_pkg::STRIDE_W-1:0] stride_new;
  logic [fbpa_pkg::IDX_W+fbpa_pkg::STRIDE_W-1:0] prod;
  logic [fbpa_pkg::CTR_W-1:0]    used_inc;
  logic                          free_ok;

  // Link memory ports.
  logic                          ram_we;
  logic [fbpa_pkg::IDX_W-1:0]    ram_waddr;
  logic [fbpa_pkg::LINK_W-1:0]   ram_wdata;
  logic                          ram_re;
  logic [fbpa_pkg::LINK_W-1:0]   ram_rdata;

  fbpa_pkg::div_req_t            div_req;
  fbpa_pkg::div_rsp_t            div_rsp;

  // Clamp, floor at one byte, round up to whole words.
  function automatic logic [fbpa_pkg::STRIDE_W-1:0] round_stride_words(
    input logic [fbpa_pkg::BYTES_W-1:0] req
  );
    logic [fbpa_pkg::BYTES_W:0] b;
    b = {1'b0, req};
    if (int'(req) > fbpa_pkg::MAX_BLOCK_BYTES) begin
      b = (fbpa_pkg::BYTES_W + 1)'(fbpa_pkg::MAX_BLOCK_BYTES);
    end
    if (b == '0) begin
      b = (fbpa_pkg::BYTES_W + 1)'(1);
    end
    b = b + (fbpa_pkg::BYTES_W + 1)'(fbpa_pkg::WORD_BYTES - 1);
    return fbpa_pkg::STRIDE_W'(b >> fbpa_pkg::WORD_SHIFT);
  endfunction

  assign busy       = (state != S_IDLE);
  assign accept     = start && !busy;
  assign cfg_ready  = 1'b1;
  assign list_empty = (head >= fbpa_pkg::LINK_NULL);

  always_comb begin
    cnt_sat = (cfg_pool_blocks > fbpa_pkg::CNT_W'(fbpa_pkg::MAX_BLOCKS))
              ? fbpa_pkg::LINK_NULL : fbpa_pkg::LINK_W'(cfg_pool_blocks);
    stride_new = round_stride_words(cfg_block_bytes);
    // block index times stride, registered before it reaches the result
    prod     = head[fbpa_pkg::IDX_W-1:0] * stride_words;
    used_inc = used + fbpa_pkg::CTR_W'(1);
    // in range and on a block boundary
    free_ok  = (div_rsp.quot < fbpa_pkg::DIVD_W'(linked)) && (div_rsp.rem == '0) &&
               (free_lsb == '0);
  end

  // Divider maps a byte offset to a block index and remainder, in words.
  always_comb begin
    div_req.go       = accept && (cmd.action == fbpa_pkg::ACT_FREE) && pool_ready;
    div_req.dividend = cmd.free_offset[fbpa_pkg::OFF_W-1:fbpa_pkg::WORD_SHIFT];
    div_req.divisor  = stride_words;
  end

  // Link memory access: init chain writes, free push, alloc pop read.
  always_comb begin
    ram_re    = accept && (cmd.action == fbpa_pkg::ACT_ALLOC) && pool_ready && !list_empty;
    ram_we    = (state == S_INIT) || ((state == S_FREE) && div_rsp.done && free_ok);
    ram_waddr = (state == S_INIT) ? init_idx : div_rsp.quot[fbpa_pkg::IDX_W-1:0];
    if (state == S_INIT) begin
      ram_wdata = (init_idx == init_last) ? fbpa_pkg::LINK_NULL
                : fbpa_pkg::LINK_W'(init_idx) + fbpa_pkg::LINK_W'(1);
    end else begin
      ram_wdata = head;
    end
  end

  fbpa_link_ram #(
    .DEPTH (fbpa_pkg::MAX_BLOCKS),
    .WIDTH (fbpa_pkg::LINK_W)
  ) u_link_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (head[fbpa_pkg::IDX_W-1:0]),
    .rdata (ram_rdata)
  );

  fbpa_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // Configuration transfers; the port is always ready.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_block_bytes <= fbpa_pkg::BYTES_W'(fbpa_pkg::RESET_BLOCK_BYTES);
      cfg_pool_blocks <= fbpa_pkg::CNT_W'(fbpa_pkg::RESET_POOL_BLOCKS);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        fbpa_pkg::CFG_BLOCK_BYTES: cfg_block_bytes <= cfg_data;
        fbpa_pkg::CFG_POOL_BLOCKS: cfg_pool_blocks <= cfg_data[fbpa_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Command sequencer and pool state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      done         <= 1'b0;
      head         <= fbpa_pkg::LINK_NULL;
      pool_ready   <= 1'b0;
      linked       <= '0;
      stride_words <= fbpa_pkg::STRIDE_W'(fbpa_pkg::RESET_STRIDE_WORDS);
      used         <= '0;
      peak         <= '0;
      alloc_ctr    <= '0;
      free_ctr     <= '0;
      fail_ctr     <= '0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            status_q  <= fbpa_pkg::ST_OK;
            off_words <= '0;
            free_lsb  <= cmd.free_offset[fbpa_pkg::WORD_SHIFT-1:0];
            unique case (cmd.action)
              fbpa_pkg::ACT_ALLOC: begin
                if (!pool_ready) begin
                  status_q <= fbpa_pkg::ST_NOT_READY;
                  done     <= 1'b1;
                end else if (list_empty) begin
                  status_q <= fbpa_pkg::ST_EXHAUSTED;
                  fail_ctr <= fail_ctr + fbpa_pkg::CTR_W'(1);
                  done     <= 1'b1;
                end else begin
                  state <= S_ALLOC;
                end
              end
              fbpa_pkg::ACT_FREE: begin
                if (!pool_ready) begin
                  status_q <= fbpa_pkg::ST_NOT_READY;
                  done     <= 1'b1;
                end else begin
                  state <= S_FREE;
                end
              end
              fbpa_pkg::ACT_RESET_STATS: begin
                peak      <= used;
                alloc_ctr <= '0;
                free_ctr  <= '0;
                fail_ctr  <= '0;
                done      <= 1'b1;
              end
              fbpa_pkg::ACT_INIT: begin
                if (cfg_pool_blocks == '0) begin
                  status_q <= fbpa_pkg::ST_BAD_COUNT;
                  done     <= 1'b1;
                end else begin
                  // latch geometry now, walk the chain from block 0
                  stride_words <= stride_new;
                  linked       <= cnt_sat;
                  init_idx     <= '0;
                  init_last    <= fbpa_pkg::IDX_W'(cnt_sat - fbpa_pkg::LINK_W'(1));
                  state        <= S_INIT;
                end
              end
              fbpa_pkg::ACT_CLEANUP: begin
                pool_ready <= 1'b0;
                head       <= fbpa_pkg::LINK_NULL;
                linked     <= '0;
                done       <= 1'b1;
              end
              default: begin
                done <= 1'b1;
              end
            endcase
          end
        end

        S_ALLOC: begin
          // pop: link of the old head becomes the new head
          head      <= ram_rdata;
          off_words <= fbpa_pkg::DIVD_W'(prod);
          used      <= used_inc;
          alloc_ctr <= alloc_ctr + fbpa_pkg::CTR_W'(1);
          if (used_inc > peak) begin
            peak <= used_inc;
          end
          done  <= 1'b1;
          state <= S_IDLE;
        end

        S_FREE: begin
          if (div_rsp.done) begin
            if (free_ok) begin
              // push: the link is written with the old head in this same cycle
              head     <= fbpa_pkg::LINK_W'(div_rsp.quot);
              used     <= (used == '0) ? used : used - fbpa_pkg::CTR_W'(1);
              free_ctr <= free_ctr + fbpa_pkg::CTR_W'(1);
            end else begin
              status_q <= fbpa_pkg::ST_FREE_REJECT;
            end
            done  <= 1'b1;
            state <= S_IDLE;
          end
        end

        S_INIT: begin
          init_idx <= init_idx + fbpa_pkg::IDX_W'(1);
          if (init_idx == init_last) begin
            head       <= '0;
            pool_ready <= 1'b1;
            used       <= '0;
            peak       <= '0;
            alloc_ctr  <= '0;
            free_ctr   <= '0;
            fail_ctr   <= '0;
            done       <= 1'b1;
            state      <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_comb begin
    result.status       = status_q;
    result.block_offset = {off_words, fbpa_pkg::WORD_SHIFT'(0)};
    result.used_count   = used[fbpa_pkg::CNT_W-1:0];
    result.peak_count   = peak[fbpa_pkg::CNT_W-1:0];
    result.alloc_total  = alloc_ctr;
    result.free_total   = free_ctr;
    result.fail_total   = fail_ctr;
    result.list_empty   = list_empty;
    result.all_free     = (used == '0);
  end

  // A result always lands with the sequencer back at rest.
  `FBPA_ASSERT_IMP(a_done_not_busy, clk, rst, done, !busy, "result strobe while busy")
  // A pop finishes in the cycle after the alloc state, with no stall.
  `FBPA_ASSERT_NEXT(a_alloc_one_cycle, clk, rst, state == S_ALLOC, done && !busy, "alloc stalled")
  // At rest the head always points inside the linked pool.
  `FBPA_ASSERT_IMP(a_head_in_pool, clk, rst, !busy && !list_empty, head < linked, "stray head")
  // A pool that is not ready holds no free blocks.
  `FBPA_ASSERT_IMP(a_idle_empty, clk, rst, !busy && !pool_ready, list_empty, "list while down")

endmodule

>>> tb/tb_fixed_block_pool_allocator_top.sv
// Self-checking testbench for the fixed block pool allocator: directed and random commands.
`timescale 1ns / 100ps

module tb_fixed_block_pool_allocator_top;
  import fbpa_pkg::*;

  // Cycles with no transfer of any kind before the run is declared hung. The slowest
  // legal quiet stretch is a 1024-block init right after the longest sender gap,
  // so this leaves several times that.
  localparam int unsigned STALL_LIMIT = 5000;
  // Settle time after the last result; well past the latency of a free.
  localparam int unsigned TAIL_CYCLES = 40;
  localparam int unsigned PHASES      = 14;
  // Action codes the block must treat as no-ops.
  localparam logic [ACTION_W-1:0] ACT_SPARE_FIRST = 3'd5;
  localparam logic [ACTION_W-1:0] ACT_SPARE_LAST  = 3'd7;
  localparam logic [OFF_W-1:0]    OFF_ALL_ONES    = '1;

  // Shadow of the allocator: tracks the free list, statistics and register values,
  // queues the expected result of every accepted command and checks results against it.
  class pool_tracker;
    int unsigned      next_link [MAX_BLOCKS];
    int unsigned      head;
    int unsigned      used;
    int unsigned      peak;
    int unsigned      linked;
    int unsigned      stride;
    bit               ready;
    logic [CTR_W-1:0] alloc_total;
    logic [CTR_W-1:0] free_total;
    logic [CTR_W-1:0] fail_total;
    int unsigned      cfg_bytes;
    int unsigned      cfg_count;
    int unsigned      live_offsets[$];
    result_t          expected_results[$];
    int unsigned      mismatches;

    function new();
      head        = MAX_BLOCKS;
      used        = 0;
      peak        = 0;
      linked      = 0;
      stride      = RESET_STRIDE_WORDS * WORD_BYTES;
      ready       = 1'b0;
      alloc_total = '0;
      free_total  = '0;
      fail_total  = '0;
      cfg_bytes   = RESET_BLOCK_BYTES;
      cfg_count   = RESET_POOL_BLOCKS;
      mismatches  = 0;
    endfunction

    function void note_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == CFG_BLOCK_BYTES) cfg_bytes = data;
      else cfg_count = data[CNT_W-1:0];
    endfunction

    function int unsigned stride_for(int unsigned req);
      int unsigned b;
      b = req;
      if (b > MAX_BLOCK_BYTES) b = MAX_BLOCK_BYTES;
      if (b == 0) b = 1;
      return ((b + WORD_BYTES - 1) / WORD_BYTES) * WORD_BYTES;
    endfunction

    function void note_command(cmd_t c);
      result_t     r;
      int unsigned blk;
      int unsigned off;
      int unsigned cnt;
      r        = '0;
      r.status = ST_OK;
      off      = c.free_offset;
      case (c.action)
        ACT_ALLOC: begin
          if (!ready) begin
            r.status = ST_NOT_READY;
          end else if (head >= MAX_BLOCKS) begin
            r.status = ST_EXHAUSTED;
            fail_total++;
          end else begin
            blk            = head;
            r.block_offset = OFF_W'(blk * stride);
            live_offsets.push_back(blk * stride);
            head = next_link[blk];
            used++;
            alloc_total++;
            if (used > peak) peak = used;
          end
        end
        ACT_FREE: begin
          if (!ready) begin
            r.status = ST_NOT_READY;
          end else begin
            blk = off / stride;
            if (blk >= linked || blk >= MAX_BLOCKS || off % stride != 0) begin
              r.status = ST_FREE_REJECT;
            end else begin
              next_link[blk] = head;
              head           = blk;
              if (used > 0) used--;
              free_total++;
              foreach (live_offsets[k]) begin
                if (live_offsets[k] == off) begin
                  live_offsets.delete(k);
                  break;
                end
              end
            end
          end
        end
        ACT_RESET_STATS: begin
          peak        = used;
          alloc_total = '0;
          free_total  = '0;
          fail_total  = '0;
        end
        ACT_INIT: begin
          cnt = cfg_count;
          if (cnt == 0) begin
            r.status = ST_BAD_COUNT;
          end else begin
            if (cnt > MAX_BLOCKS) cnt = MAX_BLOCKS;
            stride = stride_for(cfg_bytes);
            linked = cnt;
            for (int unsigned k = 0; k + 1 < cnt; k++) next_link[k] = k + 1;
            next_link[cnt-1] = MAX_BLOCKS;
            head        = 0;
            ready       = 1'b1;
            used        = 0;
            peak        = 0;
            alloc_total = '0;
            free_total  = '0;
            fail_total  = '0;
            live_offsets.delete();
          end
        end
        ACT_CLEANUP: begin
          ready  = 1'b0;
          head   = MAX_BLOCKS;
          linked = 0;
          live_offsets.delete();
        end
        default: ;
      endcase
      r.used_count  = CNT_W'(used);
      r.peak_count  = CNT_W'(peak);
      r.alloc_total = alloc_total;
      r.free_total  = free_total;
      r.fail_total  = fail_total;
      r.list_empty  = (head >= MAX_BLOCKS);
      r.all_free    = (used == 0);
      expected_results.push_back(r);
    endfunction

    task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      mismatches++;
      $display("%0t: mismatch in %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    endtask

    task check_result(result_t got);
      result_t want;
      if (expected_results.size() == 0) begin
        report_mismatch("status of a result with no command outstanding", got.status, '0);
      end else begin
        want = expected_results.pop_front();
        if (got.status !== want.status)
          report_mismatch("status", got.status, want.status);
        if (got.block_offset !== want.block_offset)
          report_mismatch("block_offset", got.block_offset, want.block_offset);
        if (got.used_count !== want.used_count)
          report_mismatch("used_count", got.used_count, want.used_count);
        if (got.peak_count !== want.peak_count)
          report_mismatch("peak_count", got.peak_count, want.peak_count);
        if (got.alloc_total !== want.alloc_total)
          report_mismatch("alloc_total", got.alloc_total, want.alloc_total);
        if (got.free_total !== want.free_total)
          report_mismatch("free_total", got.free_total, want.free_total);
        if (got.fail_total !== want.fail_total)
          report_mismatch("fail_total", got.fail_total, want.fail_total);
        if (got.list_empty !== want.list_empty)
          report_mismatch("list_empty", got.list_empty, want.list_empty);
        if (got.all_free !== want.all_free)
          report_mismatch("all_free", got.all_free, want.all_free);
      end
    endtask
  endclass

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  start     = 1'b0;
  logic                  busy;
  cmd_t                  cmd       = '0;
  logic                  done;
  result_t               result;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  pool_tracker pool = new();
  // Set for whole phases that run back to back with no sender gaps.
  bit no_gaps = 1'b0;

  fixed_block_pool_allocator_top DUT (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .cmd       (cmd),
    .done      (done),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Observe every transfer at the rising edge, in one process so that a result
  // and a new command on the same edge are always handled in the same order:
  // check the result first, then queue the expectation of the new command.
  always @(posedge clk) begin
    if (!rst) begin
      if (done) pool.check_result(result);
      if (start && !busy) pool.note_command(cmd);
      if (cfg_valid && cfg_ready) pool.note_register(cfg_index, cfg_data);
    end
  end

  // Hang detection: count edges with no transfer at all; bail out at the limit.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || done || (start && !busy) || (cfg_valid && cfg_ready)) quiet = 0;
      else quiet++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Mostly back-to-back or short gaps, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(99);
    if (no_gaps || roll < 45) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic cmd_t make_cmd(logic [ACTION_W-1:0] act, logic [OFF_W-1:0] off);
    cmd_t c;
    c.action      = act;
    c.free_offset = off;
    return c;
  endfunction

  // Draw the next command from the shadow state: mostly allocs and frees of blocks
  // that are really out, plus malformed frees, stats resets, re-inits, cleanups and
  // spare codes.
  function automatic cmd_t next_random_command();
    int unsigned      roll;
    int unsigned      span;
    logic [OFF_W-1:0] junk;
    roll = $urandom_range(99);
    span = (pool.linked == 0) ? 1 : pool.linked;
    junk = OFF_W'($urandom());
    if (roll < 38) return make_cmd(ACT_ALLOC, junk);
    if (roll < 66) begin
      if (pool.live_offsets.size() == 0) return make_cmd(ACT_ALLOC, junk);
      return make_cmd(ACT_FREE,
                      OFF_W'(pool.live_offsets[$urandom_range(pool.live_offsets.size() - 1)]));
    end
    if (roll < 77) begin
      case ($urandom_range(4))
        0: return make_cmd(ACT_FREE, junk);
        // Aligned and in range, but possibly not out: a double free.
        1: return make_cmd(ACT_FREE, OFF_W'($urandom_range(span - 1) * pool.stride));
        2: return make_cmd(ACT_FREE, OFF_W'($urandom_range(span - 1) * pool.stride
                                            + $urandom_range(1, pool.stride - 1)));
        3: return make_cmd(ACT_FREE,
                           OFF_W'((pool.linked + $urandom_range(3)) * pool.stride));
        default: return make_cmd(ACT_FREE, OFF_ALL_ONES - OFF_W'($urandom_range(pool.stride)));
      endcase
    end
    if (roll < 83) return make_cmd(ACT_RESET_STATS, junk);
    if (roll < 89) return make_cmd(ACT_INIT, junk);
    if (roll < 94) return make_cmd(ACT_CLEANUP, junk);
    if (roll < 97)
      return make_cmd(ACT_SPARE_FIRST
                      + ACTION_W'($urandom_range(ACT_SPARE_LAST - ACT_SPARE_FIRST)), junk);
    return make_cmd(ACT_ALLOC, junk);
  endfunction

  // Present one command and hold it until the transfer. Keep start high when the
  // next command follows at once; otherwise drop it and idle for the chosen gap.
  task automatic issue(cmd_t c, bit more);
    int unsigned gap;
    @(negedge clk);
    cmd   <= c;
    start <= 1'b1;
    do @(posedge clk); while (busy !== 1'b0);
    gap = pick_gap();
    if (gap != 0 || !more) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // Hold off until every expected result has come back.
  task automatic drain();
    while (pool.expected_results.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_register(cfg_reg_e idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    @(negedge clk);
    cfg_valid <= 1'b0;
    repeat (pick_gap()) @(negedge clk);
  endtask

  task automatic configure(logic [CFG_DATA_W-1:0] bytes, logic [CFG_DATA_W-1:0] count);
    if ($urandom_range(1)) begin
      write_register(CFG_BLOCK_BYTES, bytes);
      write_register(CFG_POOL_BLOCKS, count);
    end else begin
      write_register(CFG_POOL_BLOCKS, count);
      write_register(CFG_BLOCK_BYTES, bytes);
    end
  endtask

  // Walk the corner cases on the reset configuration (8-byte blocks, 1024 of them).
  task automatic run_directed();
    cmd_t script[$];
    bit   more;
    script.push_back(make_cmd(ACT_ALLOC, OFF_ALL_ONES));       // pool not ready
    script.push_back(make_cmd(ACT_FREE, '0));                  // pool not ready
    script.push_back(make_cmd(ACT_RESET_STATS, '0));
    script.push_back(make_cmd(ACT_CLEANUP, '0));
    script.push_back(make_cmd(ACT_SPARE_FIRST, '0));
    script.push_back(make_cmd(ACT_SPARE_LAST, OFF_ALL_ONES));
    script.push_back(make_cmd(ACT_INIT, '0));
    script.push_back(make_cmd(ACT_ALLOC, '0));
    script.push_back(make_cmd(ACT_ALLOC, '0));
    script.push_back(make_cmd(ACT_ALLOC, '0));
    script.push_back(make_cmd(ACT_FREE, OFF_W'(8)));           // hand block 1 back
    script.push_back(make_cmd(ACT_FREE, OFF_W'(9)));           // misaligned
    script.push_back(make_cmd(ACT_FREE, OFF_W'(MAX_BLOCKS * 8))); // just past the pool
    script.push_back(make_cmd(ACT_FREE, OFF_ALL_ONES));        // far out of range
    script.push_back(make_cmd(ACT_FREE, OFF_W'(8)));           // double free, not caught
    script.push_back(make_cmd(ACT_ALLOC, '0));
    script.push_back(make_cmd(ACT_ALLOC, '0));
    script.push_back(make_cmd(ACT_RESET_STATS, '0));
    script.push_back(make_cmd(ACT_INIT, '0));                  // rebuild while ready
    script.push_back(make_cmd(ACT_FREE, '0));                  // used already at zero
    script.push_back(make_cmd(ACT_CLEANUP, '0));
    script.push_back(make_cmd(ACT_ALLOC, '0));                 // not ready again
    script.push_back(make_cmd(ACT_FREE, OFF_W'(16)));
    foreach (script[i]) begin
      // Pause once after the double free until the block has answered everything.
      more = (i != 14) && (i + 1 < script.size());
      issue(script[i], more);
      if (i == 14) drain();
    end
  endtask

  initial begin : stimulus
    logic [CFG_DATA_W-1:0] set_bytes;
    logic [CFG_DATA_W-1:0] set_count;
    int unsigned           n_items;
    int unsigned           roll;
    bit                    pause_now;

    // Hold reset from the start, then release it away from the sampling edge.
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    run_directed();

    // One phase per register setting: fixed corners first, then random settings.
    for (int p = 0; p < PHASES; p++) begin
      drain();
      case (p)
        0: begin set_bytes = 1;     set_count = 1;    end   // smallest pool
        1: begin set_bytes = 0;     set_count = 2;    end   // zero size counts as one byte
        2: begin set_bytes = 4096;  set_count = 1024; end   // largest legal pool
        3: begin set_bytes = '1;    set_count = '1;   end   // both saturate
        4: begin set_bytes = 13;    set_count = 5;    end   // round up to a word
        5: begin set_bytes = 4095;  set_count = 3;    end
        6: begin set_bytes = 200;   set_count = 0;    end   // init is refused
        default: begin
          roll = $urandom_range(99);
          if (roll < 70) begin
            set_bytes = CFG_DATA_W'($urandom_range(1, 64));
            set_count = CFG_DATA_W'($urandom_range(1, 24));
          end else if (roll < 90) begin
            set_bytes = CFG_DATA_W'($urandom());
            set_count = CFG_DATA_W'($urandom_range(1, 2047));
          end else begin
            set_bytes = CFG_DATA_W'($urandom());
            set_count = 0;
          end
        end
      endcase
      configure(set_bytes, set_count);

      no_gaps = ($urandom_range(3) == 0);
      n_items = $urandom_range(20, 50);
      if ($urandom_range(9) != 0) issue(make_cmd(ACT_INIT, OFF_W'($urandom())), 1'b1);
      for (int i = 0; i < n_items; i++) begin
        pause_now = ($urandom_range(24) == 0);
        issue(next_random_command(), !pause_now && (i + 1 < n_items));
        if (pause_now) drain();
      end
    end

    // Let everything come back, then watch a while for stray results.
    drain();
    no_gaps = 1'b0;
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pool.mismatches == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
